[sv/rcdm_pkg.sv]
// ----------------------------------------------------------------------------
// rcdm_pkg
// Shared widths, constants, codes and control types of the drive mixer.
// ----------------------------------------------------------------------------
package rcdm_pkg;

	// field and register widths
	localparam int PULSE_W    = 12;
	localparam int OUT_W      = 11;
	localparam int ELAPSED_W  = 16;
	localparam int TIME_W     = 24;
	localparam int DB_W       = 9;
	localparam int RATE_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int AXIS_W     = 8;
	localparam int LIM_W      = RATE_W + TIME_W;

	// divider operands: scale times a mix magnitude, over the largest magnitude
	localparam int NUM_W = 17;
	localparam int DEN_W = 8;

	// pulse widths in microseconds
	localparam logic [OUT_W-1:0] NEUTRAL_US = 11'd1500;
	localparam logic [OUT_W-1:0] MIN_US     = 11'd1000;
	localparam logic [OUT_W-1:0] MAX_US     = 11'd2000;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// register reset values
	localparam logic [DB_W-1:0]   IN_DB_RST  = 9'd30;
	localparam logic [DB_W-1:0]   OUT_DB_RST = 9'd25;
	localparam logic [DB_W-1:0]   SCALE_RST  = 9'd500;
	localparam logic [RATE_W-1:0] RATE_RST   = 16'd66;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IN_DB  = 2'd0,
		CFG_OUT_DB = 2'd1,
		CFG_SCALE  = 2'd2,
		CFG_RATE   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [DB_W-1:0]   in_db;
		logic [DB_W-1:0]   out_db;
		logic [DB_W-1:0]   scale;
		logic [RATE_W-1:0] rate;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX,
		ST_START,
		ST_DIV,
		ST_TGT,
		ST_SLEW,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic mix;
		logic div_start;
		logic target;
		logic slew;
		logic load;
	} cmd_t;

	// datapath and output side to controller
	typedef struct packed {
		logic miss;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

[sv/rcdm_div.sv]
// ----------------------------------------------------------------------------
// rcdm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcdm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rcdm_pkg::NUM_W-1:0] num,
	input  logic [rcdm_pkg::DEN_W-1:0] den,
	output logic                       done,
	output logic [rcdm_pkg::NUM_W-1:0] quo,
	output logic                       rem_nz
);
	import rcdm_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;

	// trial subtract of the shifted partial remainder
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = ge ? (trial - {1'b0, den_q}) : trial;
	end

	// control: step counter, busy and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// operands: load on start, shift one bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= diff[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done   = done_q;
	assign quo    = quo_q;
	assign rem_nz = |rem_q;

endmodule

[sv/rcdm_ctrl.sv]
// ----------------------------------------------------------------------------
// rcdm_ctrl
// Sequencer: one item through mix, divide, target, slew; misses skip to done.
// ----------------------------------------------------------------------------
module rcdm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rcdm_pkg::sts_t sts,
	output rcdm_pkg::cmd_t cmd
);
	import rcdm_pkg::*;

	state_t state_q;
	state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_MIX;
			ST_MIX:   state_d = sts.miss ? ST_DONE : ST_START;
			ST_START: state_d = ST_DIV;
			ST_DIV:   if (sts.div_done) state_d = ST_TGT;
			ST_TGT:   state_d = ST_SLEW;
			ST_SLEW:  state_d = ST_DONE;
			ST_DONE:  if (sts.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_MIX:   cmd.mix       = 1'b1;
			ST_START: cmd.div_start = 1'b1;
			ST_TGT:   cmd.target    = 1'b1;
			ST_SLEW:  cmd.slew      = 1'b1;
			ST_DONE:  cmd.load      = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/rcdm_dp.sv]
// ----------------------------------------------------------------------------
// rcdm_dp
// Datapath: input snap and map, mix, normalising division, slew and deadzone.
// ----------------------------------------------------------------------------
module rcdm_dp #(
	parameter int RATE_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rcdm_pkg::cmd_t                 cmd,
	input  rcdm_pkg::cfg_t                 cfg,
	input  logic [rcdm_pkg::PULSE_W-1:0]   steer_pulse_us,
	input  logic [rcdm_pkg::PULSE_W-1:0]   throttle_pulse_us,
	input  logic [rcdm_pkg::PULSE_W-1:0]   orient_pulse_us,
	input  logic [rcdm_pkg::ELAPSED_W-1:0] elapsed_us,
	output logic                           miss,
	output logic                           div_done,
	output logic [rcdm_pkg::OUT_W-1:0]     res_left,
	output logic [rcdm_pkg::OUT_W-1:0]     res_right,
	output logic                           res_no_signal,
	output logic                           res_flipped
);
	import rcdm_pkg::*;

	// floor(v/5) as (v*205)>>10, exact for v below 1024
	localparam int                RECIP5_SH = 10;
	localparam logic [17:0]       RECIP5    = 18'd205;
	localparam logic signed [8:0] AXIS_OFS  = 9'sd100;

	// snap near neutral, then clamp to the servo range
	function automatic logic [OUT_W-1:0] snap_clamp(input logic [PULSE_W-1:0] w,
			input logic [DB_W-1:0] db);
		logic [PULSE_W-1:0] lo;
		logic [PULSE_W-1:0] hi;
		logic [PULSE_W-1:0] v;
		lo = PULSE_W'(NEUTRAL_US) - PULSE_W'(db);
		hi = PULSE_W'(NEUTRAL_US) + PULSE_W'(db);
		v  = w;
		if (w > lo && w < hi) v = PULSE_W'(NEUTRAL_US);
		if (v < PULSE_W'(MIN_US)) v = PULSE_W'(MIN_US);
		else if (v > PULSE_W'(MAX_US)) v = PULSE_W'(MAX_US);
		return v[OUT_W-1:0];
	endfunction

	// map 1000..2000 to -100..100
	function automatic logic signed [AXIS_W-1:0] to_axis(input logic [OUT_W-1:0] w);
		logic [17:0]       prod;
		logic signed [8:0] t;
		prod = 18'(w - MIN_US) * RECIP5;
		t    = $signed({1'b0, prod[RECIP5_SH+7:RECIP5_SH]}) - AXIS_OFS;
		return t[AXIS_W-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] clamp13(input logic signed [12:0] v);
		if (v < $signed({2'b00, MIN_US})) return MIN_US;
		if (v > $signed({2'b00, MAX_US})) return MAX_US;
		return v[OUT_W-1:0];
	endfunction

	// neutral band on the final pulse
	function automatic logic [OUT_W-1:0] out_band(input logic [OUT_W-1:0] p,
			input logic [DB_W-1:0] db);
		logic [PULSE_W-1:0] lo;
		logic [PULSE_W-1:0] hi;
		lo = PULSE_W'(NEUTRAL_US) - PULSE_W'(db);
		hi = PULSE_W'(NEUTRAL_US) + PULSE_W'(db);
		if (PULSE_W'(p) > lo && PULSE_W'(p) < hi) return NEUTRAL_US;
		return p;
	endfunction

	// limit the step from the past value; up by floor, down by ceil of the limit
	function automatic logic [OUT_W-1:0] slew(input logic [OUT_W-1:0] past,
			input logic [OUT_W-1:0] tgt, input logic [11:0] lf, input logic [11:0] lc);
		logic [OUT_W-1:0] ds;
		logic [OUT_W-1:0] r;
		r  = tgt;
		ds = '0;
		if (tgt > past) begin
			ds = tgt - past;
			if (12'(ds) > lf) r = past + lf[OUT_W-1:0];
		end else if (tgt < past) begin
			ds = past - tgt;
			if (12'(ds) > lf) r = past - lc[OUT_W-1:0];
		end
		return r;
	endfunction

	// item registers
	logic signed [AXIS_W-1:0] x_q;
	logic signed [AXIS_W-1:0] y_q;
	logic                     flip_q;
	logic                     miss_q;
	logic [TIME_W-1:0]        t_q;

	// mix registers
	logic              sneg_q;
	logic              dneg_q;
	logic              swap_q;
	logic [NUM_W-1:0]  num_l_q;
	logic [NUM_W-1:0]  num_r_q;
	logic [DEN_W-1:0]  m_q;
	logic [LIM_W-1:0]  lim_q;

	// target and state registers
	logic [OUT_W-1:0]  tgt_l_q;
	logic [OUT_W-1:0]  tgt_r_q;
	logic [OUT_W-1:0]  left_past_q;
	logic [OUT_W-1:0]  right_past_q;
	logic [TIME_W-1:0] time_q;

	logic [OUT_W-1:0]  res_left_q;
	logic [OUT_W-1:0]  res_right_q;
	logic              res_no_signal_q;
	logic              res_flipped_q;

	// capture stage
	logic              any_zero;
	logic [TIME_W:0]   t_sum;
	logic [TIME_W-1:0] t_sat;

	always_comb begin
		any_zero = (steer_pulse_us == '0) || (throttle_pulse_us == '0) ||
			(orient_pulse_us == '0);
		t_sum = {1'b0, time_q} + (TIME_W+1)'(elapsed_us);
		t_sat = (t_sum > {1'b0, TIME_MAX}) ? TIME_MAX : t_sum[TIME_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q    <= to_axis(snap_clamp(steer_pulse_us, cfg.in_db));
			y_q    <= to_axis(snap_clamp(throttle_pulse_us, cfg.in_db));
			flip_q <= snap_clamp(orient_pulse_us, cfg.in_db) >= NEUTRAL_US;
			miss_q <= any_zero;
			t_q    <= t_sat;
		end
	end

	// mix stage: sum, difference, magnitudes, scaled numerators, slew limit
	logic signed [AXIS_W:0] s;
	logic signed [AXIS_W:0] d;
	logic [AXIS_W:0]        s_abs;
	logic [AXIS_W:0]        d_abs;

	always_comb begin
		s     = {x_q[AXIS_W-1], x_q} + {y_q[AXIS_W-1], y_q};
		d     = {y_q[AXIS_W-1], y_q} - {x_q[AXIS_W-1], x_q};
		s_abs = s[AXIS_W] ? -s : s;
		d_abs = d[AXIS_W] ? -d : d;
	end

	always_ff @(posedge clk) begin
		if (cmd.mix) begin
			sneg_q  <= s[AXIS_W];
			dneg_q  <= d[AXIS_W];
			swap_q  <= !flip_q && y_q[AXIS_W-1];
			num_l_q <= NUM_W'(cfg.scale) * NUM_W'(s_abs[DEN_W-1:0]);
			num_r_q <= NUM_W'(cfg.scale) * NUM_W'(d_abs[DEN_W-1:0]);
			m_q     <= (s_abs > d_abs) ? s_abs[DEN_W-1:0] : d_abs[DEN_W-1:0];
			lim_q   <= LIM_W'(cfg.rate) * LIM_W'(t_q);
		end
	end

	// normalise both sides in parallel lanes
	logic [NUM_W-1:0] quo_l;
	logic [NUM_W-1:0] quo_r;
	logic             rnz_l;
	logic             rnz_r;
	logic             done_l;
	logic             done_r;

	rcdm_div u_div_l (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_l_q),
		.den    (m_q),
		.done   (done_l),
		.quo    (quo_l),
		.rem_nz (rnz_l)
	);

	rcdm_div u_div_r (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_r_q),
		.den    (m_q),
		.done   (done_r),
		.quo    (quo_r),
		.rem_nz (rnz_r)
	);

	// target stage: floor the signed quotient, offset, swap, clamp
	logic [11:0]        mag_l;
	logic [11:0]        mag_r;
	logic signed [12:0] off_l;
	logic signed [12:0] off_r;
	logic [OUT_W-1:0]   cl_l;
	logic [OUT_W-1:0]   cl_r;

	always_comb begin
		mag_l = 12'(quo_l[9:0]) + 12'(rnz_l);
		mag_r = 12'(quo_r[9:0]) + 12'(rnz_r);
		off_l = sneg_q ? -$signed({1'b0, mag_l}) : $signed({3'b000, quo_l[9:0]});
		off_r = dneg_q ? -$signed({1'b0, mag_r}) : $signed({3'b000, quo_r[9:0]});
		cl_l  = clamp13($signed({2'b00, NEUTRAL_US}) + off_l);
		cl_r  = clamp13($signed({2'b00, NEUTRAL_US}) + off_r);
	end

	always_ff @(posedge clk) begin
		if (cmd.target) begin
			if (m_q == '0) begin
				tgt_l_q <= NEUTRAL_US;
				tgt_r_q <= NEUTRAL_US;
			end else if (swap_q) begin
				tgt_l_q <= cl_r;
				tgt_r_q <= cl_l;
			end else begin
				tgt_l_q <= cl_l;
				tgt_r_q <= cl_r;
			end
		end
	end

	// slew stage: whole and rounded-up step allowed by the limit
	logic [LIM_W-1:0]  lf_full;
	logic [LIM_W-1:0]  frac_mask;
	logic              frac_nz;
	logic [11:0]       lf_sat;
	logic [11:0]       lc_sat;
	logic [OUT_W-1:0]  new_l;
	logic [OUT_W-1:0]  new_r;

	always_comb begin
		lf_full   = lim_q >> RATE_FRAC_BITS;
		frac_mask = (LIM_W'(1) << RATE_FRAC_BITS) - LIM_W'(1);
		frac_nz   = |(lim_q & frac_mask);
		lf_sat    = (lf_full > LIM_W'(12'hFFF)) ? 12'hFFF : lf_full[11:0];
		lc_sat    = lf_sat + 12'(frac_nz);
		new_l     = slew(left_past_q, tgt_l_q, lf_sat, lc_sat);
		new_r     = slew(right_past_q, tgt_r_q, lf_sat, lc_sat);
	end

	// past values and time accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_past_q  <= NEUTRAL_US;
			right_past_q <= NEUTRAL_US;
			time_q       <= '0;
		end else if (cmd.mix && miss_q) begin
			time_q <= t_q;
		end else if (cmd.slew) begin
			left_past_q  <= new_l;
			right_past_q <= new_r;
			time_q       <= '0;
		end
	end

	// result of the item
	always_ff @(posedge clk) begin
		if (cmd.mix && miss_q) begin
			res_left_q      <= NEUTRAL_US;
			res_right_q     <= NEUTRAL_US;
			res_no_signal_q <= 1'b1;
			res_flipped_q   <= 1'b0;
		end else if (cmd.slew) begin
			res_left_q      <= out_band(new_l, cfg.out_db);
			res_right_q     <= out_band(new_r, cfg.out_db);
			res_no_signal_q <= 1'b0;
			res_flipped_q   <= flip_q;
		end
	end

	assign miss          = miss_q;
	assign div_done      = done_l & done_r;
	assign res_left      = res_left_q;
	assign res_right     = res_right_q;
	assign res_no_signal = res_no_signal_q;
	assign res_flipped   = res_flipped_q;

endmodule

[sv/rc_differential_drive_mixer.sv]
// ----------------------------------------------------------------------------
// rc_differential_drive_mixer
// Arcade mixer for a differential drive with input snap, slew limit and
// output deadzone.
// ----------------------------------------------------------------------------
// One item is in work at a time. A normal item passes from acceptance to
// its result standing in the output register through the accept step, a
// mix step, a divider start, the two 17-step restoring dividers that
// normalise left and right side by side, and target, slew and hand-over
// steps. An item with a missing channel (any pulse width zero) skips the
// division. The output register holds a finished result while the next
// item is accepted and worked on. Configuration writes are taken in any
// cycle and must only be issued while the block is idle.
module rc_differential_drive_mixer #(
	parameter int RATE_FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rcdm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcdm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rcdm_pkg::PULSE_W-1:0]    steer_pulse_us,
	input  logic [rcdm_pkg::PULSE_W-1:0]    throttle_pulse_us,
	input  logic [rcdm_pkg::PULSE_W-1:0]    orient_pulse_us,
	input  logic [rcdm_pkg::ELAPSED_W-1:0]  elapsed_us,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rcdm_pkg::OUT_W-1:0]      left_pulse_us,
	output logic [rcdm_pkg::OUT_W-1:0]      right_pulse_us,
	output logic                            no_signal,
	output logic                            flipped
);
	import rcdm_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	logic             dp_miss;
	logic             dp_div_done;
	logic [OUT_W-1:0] res_left;
	logic [OUT_W-1:0] res_right;
	logic             res_no_signal;
	logic             res_flipped;

	logic             out_valid_q;
	logic [OUT_W-1:0] left_q;
	logic [OUT_W-1:0] right_q;
	logic             no_signal_q;
	logic             flipped_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_db  <= IN_DB_RST;
			cfg_q.out_db <= OUT_DB_RST;
			cfg_q.scale  <= SCALE_RST;
			cfg_q.rate   <= RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_IN_DB:  cfg_q.in_db  <= cfg_data[DB_W-1:0];
				CFG_OUT_DB: cfg_q.out_db <= cfg_data[DB_W-1:0];
				CFG_SCALE:  cfg_q.scale  <= cfg_data[DB_W-1:0];
				CFG_RATE:   cfg_q.rate   <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// status to the sequencer
	always_comb begin
		sts.miss     = dp_miss;
		sts.div_done = dp_div_done;
		sts.out_free = !out_valid_q || out_ready;
	end

	rcdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rcdm_dp #(
		.RATE_FRAC_BITS (RATE_FRAC_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cfg               (cfg_q),
		.steer_pulse_us    (steer_pulse_us),
		.throttle_pulse_us (throttle_pulse_us),
		.orient_pulse_us   (orient_pulse_us),
		.elapsed_us        (elapsed_us),
		.miss              (dp_miss),
		.div_done          (dp_div_done),
		.res_left          (res_left),
		.res_right         (res_right),
		.res_no_signal     (res_no_signal),
		.res_flipped       (res_flipped)
	);

	// output register: hold a beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			left_q      <= res_left;
			right_q     <= res_right;
			no_signal_q <= res_no_signal;
			flipped_q   <= res_flipped;
		end
	end

	assign out_valid      = out_valid_q;
	assign left_pulse_us  = left_q;
	assign right_pulse_us = right_q;
	assign no_signal      = no_signal_q;
	assign flipped        = flipped_q;

	// a result never overwrites a beat that is still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || out_ready))
		else $error("result loaded over a waiting beat");

	// a loaded result is offered in the next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid)
		else $error("loaded result not offered");

	// a missing-signal beat is neutral and unflipped
	a_miss_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_signal) |->
			(left_pulse_us == NEUTRAL_US && right_pulse_us == NEUTRAL_US && !flipped))
		else $error("missing-signal beat not neutral");

	// every offered pulse lies in the servo range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_pulse_us >= MIN_US && left_pulse_us <= MAX_US &&
			right_pulse_us >= MIN_US && right_pulse_us <= MAX_US))
		else $error("pulse out of servo range");

endmodule

[tb/rc_differential_drive_mixer_tb.sv]
// ----------------------------------------------------------------------------
// rc_differential_drive_mixer_tb
// Self-checking bench for the arcade drive mixer. Readings are sent through
// the input handshake with random gaps, and results are drained with random
// back-pressure. An in-bench model of snap, mix, slew and deadzone predicts
// every result, which is then compared field by field. Register settings
// change between groups of readings, only while no result is outstanding.
// ----------------------------------------------------------------------------
module rc_differential_drive_mixer_tb;

	import rcdm_pkg::*;

	localparam int FRAC_BITS      = 16;
	localparam int NEUTRAL        = NEUTRAL_US;
	localparam int LOW_US         = MIN_US;
	localparam int HIGH_US        = MAX_US;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_REPORTS    = 30;

	typedef struct packed {
		logic [OUT_W-1:0] left;
		logic [OUT_W-1:0] right;
		logic             no_sig;
		logic             flip;
	} drive_cmd_t;

	logic                  clk;
	logic                  arst_n            = 1'b0;
	logic                  cfg_valid         = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index         = '0;
	logic [CFG_DATA_W-1:0] cfg_data          = '0;
	logic                  in_valid          = 1'b0;
	logic                  in_ready;
	logic [PULSE_W-1:0]    steer_pulse_us    = '0;
	logic [PULSE_W-1:0]    throttle_pulse_us = '0;
	logic [PULSE_W-1:0]    orient_pulse_us   = '0;
	logic [ELAPSED_W-1:0]  elapsed_us        = '0;
	logic                  out_valid;
	logic                  out_ready         = 1'b0;
	logic [OUT_W-1:0]      left_pulse_us;
	logic [OUT_W-1:0]      right_pulse_us;
	logic                  no_signal;
	logic                  flipped;

	// register copies held by the bench
	int              in_db_us;
	int              out_db_us;
	int              scale_us;
	logic [RATE_W-1:0] rate_q;

	// drive state copies
	logic [OUT_W-1:0]  left_held;
	logic [OUT_W-1:0]  right_held;
	logic [TIME_W-1:0] idle_time_us;

	drive_cmd_t pending_cmds[$];

	int idle_pct        = 38;
	int stall_pct       = 38;
	int mismatch_count  = 0;
	int readings_sent   = 0;
	int results_checked = 0;
	int regs_written    = 0;
	int random_settings = 0;
	int quiet_cycles    = 0;

	rc_differential_drive_mixer #(
		.RATE_FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.steer_pulse_us   (steer_pulse_us),
		.throttle_pulse_us(throttle_pulse_us),
		.orient_pulse_us  (orient_pulse_us),
		.elapsed_us       (elapsed_us),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.left_pulse_us    (left_pulse_us),
		.right_pulse_us   (right_pulse_us),
		.no_signal        (no_signal),
		.flipped          (flipped)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Drive model
	// ------------------------------------------------------------------

	function automatic int clamp_us(int v);
		if (v < LOW_US) return LOW_US;
		if (v > HIGH_US) return HIGH_US;
		return v;
	endfunction

	// snap near neutral, then clamp to the servo range
	function automatic int snap_clamp(logic [PULSE_W-1:0] raw);
		int w;
		w = int'(raw);
		if (w > NEUTRAL - in_db_us && w < NEUTRAL + in_db_us) w = NEUTRAL;
		return clamp_us(w);
	endfunction

	function automatic int floor_div(int a, int b);
		int q;
		q = a / b;
		if ((a % b) != 0 && a < 0) q--;
		return q;
	endfunction

	// limit the step from the held value; rises round down, falls round up
	function automatic logic [OUT_W-1:0] slew_side(logic [OUT_W-1:0] held,
			logic [OUT_W-1:0] tgt, logic [63:0] lim);
		logic [63:0] ds;
		logic [63:0] one;
		one = 64'd1 << FRAC_BITS;
		if (tgt > held) begin
			ds = 64'(tgt) - 64'(held);
			if ((ds << FRAC_BITS) > lim) return held + OUT_W'(lim >> FRAC_BITS);
		end else if (tgt < held) begin
			ds = 64'(held) - 64'(tgt);
			if ((ds << FRAC_BITS) > lim)
				return held - OUT_W'((lim + one - 64'd1) >> FRAC_BITS);
		end
		return tgt;
	endfunction

	function automatic logic [OUT_W-1:0] deadzone_out(logic [OUT_W-1:0] p);
		int v;
		v = int'(p);
		if (v > NEUTRAL - out_db_us && v < NEUTRAL + out_db_us) return NEUTRAL_US;
		return p;
	endfunction

	// work out the result of one reading and advance the drive state
	function automatic drive_cmd_t predict_drive(logic [PULSE_W-1:0] st,
			logic [PULSE_W-1:0] th, logic [PULSE_W-1:0] ori,
			logic [ELAPSED_W-1:0] el);
		drive_cmd_t  r;
		int unsigned t;
		int          x, y, s, d, as, ad, m, lft, rgt, tmp;
		logic        flip;
		logic [63:0] lim;
		t = 32'(idle_time_us) + 32'(el);
		if (t > 32'(TIME_MAX)) t = 32'(TIME_MAX);
		if (st == '0 || th == '0 || ori == '0) begin
			idle_time_us = t[TIME_W-1:0];
			r.left   = NEUTRAL_US;
			r.right  = NEUTRAL_US;
			r.no_sig = 1'b1;
			r.flip   = 1'b0;
			return r;
		end
		x = floor_div(snap_clamp(st) - LOW_US, 5) - 100;
		y = floor_div(snap_clamp(th) - LOW_US, 5) - 100;
		flip = snap_clamp(ori) >= NEUTRAL;
		s = x + y;
		d = y - x;
		as = (s < 0) ? -s : s;
		ad = (d < 0) ? -d : d;
		m = (as > ad) ? as : ad;
		lft = NEUTRAL;
		rgt = NEUTRAL;
		if (m != 0) begin
			lft = NEUTRAL + floor_div(scale_us * s, m);
			rgt = NEUTRAL + floor_div(scale_us * d, m);
			// normal mode reverses steering when backing up
			if (!flip && y < 0) begin
				tmp = lft;
				lft = rgt;
				rgt = tmp;
			end
		end
		lft = clamp_us(lft);
		rgt = clamp_us(rgt);
		lim = 64'(rate_q) * 64'(t);
		left_held    = slew_side(left_held, OUT_W'(lft), lim);
		right_held   = slew_side(right_held, OUT_W'(rgt), lim);
		idle_time_us = '0;
		r.left   = deadzone_out(left_held);
		r.right  = deadzone_out(right_held);
		r.no_sig = 1'b0;
		r.flip   = flip;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Reporting and result checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, int got, int want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch at result %0d: %s got %0d, expected %0d",
				results_checked, what, got, want);
	endtask

	// random back-pressure on the result side
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		drive_cmd_t want;
		if (out_valid && out_ready) begin
			if (pending_cmds.size() == 0) begin
				report_mismatch("result with nothing pending, left", left_pulse_us, 0);
			end else begin
				want = pending_cmds.pop_front();
				if (left_pulse_us !== want.left)
					report_mismatch("left_pulse_us", left_pulse_us, want.left);
				if (right_pulse_us !== want.right)
					report_mismatch("right_pulse_us", right_pulse_us, want.right);
				if (no_signal !== want.no_sig)
					report_mismatch("no_signal", no_signal, want.no_sig);
				if (flipped !== want.flip)
					report_mismatch("flipped", flipped, want.flip);
			end
			results_checked++;
		end
	end

	// end the run when no beat moves on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results pending",
					quiet_cycles, pending_cmds.size());
				$display("FAIL rc_differential_drive_mixer");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// offer one reading; valid is left high so the next one can follow on
	task automatic send_reading(logic [PULSE_W-1:0] st, logic [PULSE_W-1:0] th,
			logic [PULSE_W-1:0] ori, logic [ELAPSED_W-1:0] el);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid          <= 1'b1;
		steer_pulse_us    <= st;
		throttle_pulse_us <= th;
		orient_pulse_us   <= ori;
		elapsed_us        <= el;
		do @(posedge clk); while (!in_ready);
		pending_cmds.push_back(predict_drive(st, th, ori, el));
		readings_sent++;
	endtask

	// drop valid and wait until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_IN_DB:  in_db_us  = int'(data[DB_W-1:0]);
			CFG_OUT_DB: out_db_us = int'(data[DB_W-1:0]);
			CFG_SCALE:  scale_us  = int'(data[DB_W-1:0]);
			CFG_RATE:   rate_q    = data[RATE_W-1:0];
			default: ;
		endcase
		regs_written++;
	endtask

	// write all four registers; spare upper data bits of the 9-bit fields carry junk
	task automatic program_regs(int in_db, int out_db, int scale, int rate);
		drain_results();
		write_reg(CFG_IN_DB,  {7'($urandom_range(127)), 9'(in_db)});
		write_reg(CFG_OUT_DB, {7'($urandom_range(127)), 9'(out_db)});
		write_reg(CFG_SCALE,  {7'($urandom_range(127)), 9'(scale)});
		write_reg(CFG_RATE,   16'(rate));
		cfg_valid <= 1'b0;
	endtask

	// mostly plausible stick positions, some wild values and dropouts
	task automatic send_random_reading();
		logic [PULSE_W-1:0]   w [3];
		logic [ELAPSED_W-1:0] el;
		int                   kind;
		int                   r;
		kind = $urandom_range(99);
		for (int i = 0; i < 3; i++) begin
			r = $urandom_range(9);
			if (kind < 20)
				w[i] = PULSE_W'($urandom_range(4095));
			else if (r < 3)
				w[i] = PULSE_W'($urandom_range(1440, 1560));
			else
				w[i] = PULSE_W'($urandom_range(950, 2050));
		end
		if (kind < 8) w[$urandom_range(2)] = '0;
		r = $urandom_range(99);
		if (r < 10)
			el = '0;
		else if (r < 35)
			el = ELAPSED_W'($urandom_range(200));
		else if (r < 80)
			el = ELAPSED_W'($urandom_range(20000));
		else
			el = ELAPSED_W'($urandom_range(65535));
		send_reading(w[0], w[1], w[2], el);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// stick extremes, band edges, both mixing modes and dropouts
	task automatic test_directed();
		send_reading(12'd1500, 12'd1500, 12'd1000, 16'd1000);
		send_reading(12'd2000, 12'd1500, 12'd1000, 16'd65535);
		send_reading(12'd1000, 12'd1500, 12'd1000, 16'd65535);
		send_reading(12'd1500, 12'd2000, 12'd1000, 16'd65535);
		send_reading(12'd1500, 12'd1000, 12'd1000, 16'd65535);
		send_reading(12'd1500, 12'd1000, 12'd2000, 16'd65535);
		send_reading(12'd4095, 12'd4095, 12'd4095, 16'd65535);
		send_reading(12'd1, 12'd1, 12'd1, 16'd65535);
		send_reading(12'd1471, 12'd1529, 12'd1499, 16'd100);
		send_reading(12'd1470, 12'd1530, 12'd1500, 16'd100);
		send_reading(12'd2000, 12'd2000, 12'd1000, 16'd0);
		send_reading(12'd0, 12'd1500, 12'd1500, 16'd500);
		send_reading(12'd1500, 12'd0, 12'd1500, 16'd500);
		send_reading(12'd1500, 12'd1500, 12'd0, 16'd500);
		send_reading(12'd0, 12'd0, 12'd0, 16'd65535);
		send_reading(12'd1000, 12'd1000, 12'd1000, 16'd65535);
		// full rate so targets land; pulses just outside the output band
		program_regs(30, 25, 25, 65535);
		send_reading(12'd2000, 12'd1500, 12'd1500, 16'd65535);
		send_reading(12'd1500, 12'd1000, 12'd1000, 16'd65535);
		// and just inside it
		program_regs(30, 25, 24, 65535);
		send_reading(12'd2000, 12'd1500, 12'd1500, 16'd65535);
		send_reading(12'd1000, 12'd2000, 12'd1500, 16'd40000);
	endtask

	task automatic test_register_extremes();
		int settings [5][4] = '{
			'{0, 0, 0, 0},
			'{500, 500, 500, 65535},
			'{511, 511, 511, 1},
			'{0, 500, 1, 65535},
			'{500, 0, 511, 300}
		};
		foreach (settings[k]) begin
			program_regs(settings[k][0], settings[k][1], settings[k][2], settings[k][3]);
			repeat (20) send_random_reading();
		end
	endtask

	// pile up dropout time until the accumulator saturates, then move
	task automatic test_time_saturation();
		program_regs(30, 25, 500, 1);
		repeat (258) send_reading(12'd0, 12'd1500, 12'd1500, 16'd65535);
		send_reading(12'd2000, 12'd2000, 12'd1000, 16'd65535);
		repeat (2) send_reading(12'd0, 12'd1500, 12'd1500, 16'd65535);
		send_reading(12'd1000, 12'd1000, 12'd1500, 16'd65535);
	endtask

	task automatic test_back_to_back();
		program_regs(30, 25, 500, 4000);
		idle_pct  = 0;
		stall_pct = 0;
		repeat (150) send_random_reading();
		drain_results();
		idle_pct  = 38;
		stall_pct = 38;
	endtask

	task automatic test_random_settings();
		int in_db, out_db, scale, rate, r;
		repeat (12) begin
			in_db  = ($urandom_range(9) < 4) ? $urandom_range(60) : $urandom_range(511);
			out_db = ($urandom_range(9) < 4) ? $urandom_range(60) : $urandom_range(511);
			scale  = ($urandom_range(9) < 7) ? $urandom_range(300, 511) : $urandom_range(511);
			r = $urandom_range(9);
			if (r < 3)
				rate = $urandom_range(200);
			else if (r < 7)
				rate = $urandom_range(200, 5000);
			else
				rate = $urandom_range(65535);
			program_regs(in_db, out_db, scale, rate);
			random_settings++;
			repeat (50) send_random_reading();
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		in_db_us     = IN_DB_RST;
		out_db_us    = OUT_DB_RST;
		scale_us     = SCALE_RST;
		rate_q       = RATE_RST;
		left_held    = NEUTRAL_US;
		right_held   = NEUTRAL_US;
		idle_time_us = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_register_extremes();
		test_time_saturation();
		test_back_to_back();
		test_random_settings();

		drain_results();
		repeat (40) @(posedge clk);
		if (pending_cmds.size() != 0)
			report_mismatch("results never delivered", pending_cmds.size(), 0);

		$display("covered %0d readings, %0d results, %0d register writes, %0d mismatches",
			readings_sent, results_checked, regs_written, mismatch_count);
		$display("phases: directed, register extremes, saturation, back-to-back, %0d random",
			random_settings);
		if (mismatch_count == 0) begin
			$display("PASS rc_differential_drive_mixer");
		end else begin
			$display("FAIL rc_differential_drive_mixer");
		end
		$finish;
	end

endmodule
